### rtl/ppfl_pkg.sv
package ppfl_pkg;

  // page size in bytes, a power of two
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PB_LOG     = $clog2(PAGE_BYTES);

  // fixed field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDR      = 3'd4;

  // configuration reset values
  localparam logic [12:0] TOTAL_PAGES_RST    = 13'd4096;
  localparam logic [11:0] FIRST_FREE_RST     = 12'd1;
  localparam logic [12:0] RESERVED_START_RST = 13'd160;
  localparam logic [12:0] KERNEL_END_RST     = 13'd256;
  localparam logic [31:0] MIN_ADDR_RST       = 32'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_BAD_ADDR = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic init_start;
    logic set_range2;
    logic walk_step;
    logic tail;
    logic free_commit;
    logic query_load;
    logic alloc_commit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic in_range1;
    logic in_range2;
    logic out_free;
  } sts_t;

endpackage

### rtl/ppfl_ctrl.sv
module ppfl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  ppfl_pkg::cmd_e   command_i,
  input  ppfl_pkg::sts_t   sts_i,
  output ppfl_pkg::ctrl_t  ctrl_o
);
  import ppfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK1,
    S_WALK2
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_INIT: begin
              ctrl_o.init_start = 1'b1;
              state_d = S_WALK1;
            end
            CMD_ALLOC: state_d = S_ALLOC;
            CMD_FREE:  ctrl_o.free_commit = 1'b1;
            CMD_QUERY: ctrl_o.query_load = 1'b1;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      // table read of the head link has landed
      S_ALLOC: begin
        ctrl_o.alloc_commit = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK1: begin
        if (sts_i.in_range1) begin
          ctrl_o.walk_step = 1'b1;
        end else begin
          ctrl_o.set_range2 = 1'b1;
          state_d = S_WALK2;
        end
      end
      S_WALK2: begin
        if (sts_i.in_range2) begin
          ctrl_o.walk_step = 1'b1;
        end else begin
          ctrl_o.tail = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/ppfl_dp.sv
module ppfl_dp #(
  parameter int unsigned PAGE_COUNT = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [ppfl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ppfl_pkg::CFG_W-1:0]         cfg_data_i,
  input  ppfl_pkg::ctrl_t                    ctrl_i,
  output ppfl_pkg::sts_t                     sts_o,
  input  logic [ppfl_pkg::ADDR_W-1:0]        address_i,
  input  logic                               m_ready_i,
  output logic                               m_valid_o,
  output logic [ppfl_pkg::OUT_W-1:0]         m_data_o
);
  import ppfl_pkg::*;

  localparam int unsigned IdxW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned LinkW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned PW    = (LinkW > 13) ? LinkW : 13;
  localparam logic [LinkW-1:0] NULL_LINK = LinkW'(PAGE_COUNT);
  localparam logic [PW-1:0]    PC_P      = PW'(PAGE_COUNT);

  // configuration
  logic [12:0] total_q, res_start_q, kern_end_q;
  logic [11:0] first_free_q;
  logic [31:0] min_addr_q;

  // list state
  logic [LinkW-1:0]   head_q, head_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [LinkW-1:0]   rd_q;

  // init walk
  logic [PW-1:0]   p_q, p_d;
  logic [IdxW-1:0] prev_q, prev_d;
  logic            have_prev_q, have_prev_d;
  // last step linked a page to itself, the tail keeps that link
  logic            self_link_q, self_link_d;

  // output word
  logic               m_valid_q, m_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  status_e            out_sts_q, out_sts_d;
  logic [COUNT_W-1:0] out_cnt_q;

  logic [LinkW-1:0] link_mem [PAGE_COUNT];
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic [LinkW-1:0] wdata;

  logic            head_null, rd_null, addr_ok, load_out;
  logic [IdxW-1:0] page_idx;
  logic [PW-1:0]   hi1, hi2, res_p, tot_p;

  assign res_p = PW'(res_start_q);
  assign tot_p = PW'(total_q);
  assign hi1   = (res_p < PC_P) ? res_p : PC_P;
  assign hi2   = (tot_p < PC_P) ? tot_p : PC_P;

  assign sts_o.in_range1 = p_q < hi1;
  assign sts_o.in_range2 = p_q < hi2;
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

  assign head_null = head_q >= NULL_LINK;
  assign rd_null   = rd_q >= NULL_LINK;
  assign page_idx  = address_i[PB_LOG +: IdxW];
  assign addr_ok   = (address_i[PB_LOG-1:0] == '0) && (address_i >= min_addr_q) &&
                     ((address_i >> PB_LOG) < 32'(PAGE_COUNT));
  assign load_out  = ctrl_i.free_commit | ctrl_i.query_load |
                     ctrl_i.alloc_commit | ctrl_i.tail;

  // single table write port
  always_comb begin
    we    = 1'b0;
    waddr = prev_q;
    wdata = NULL_LINK;
    if (ctrl_i.free_commit && addr_ok) begin
      we    = 1'b1;
      waddr = page_idx;
      wdata = head_q;
    end else if (ctrl_i.walk_step && have_prev_q) begin
      we    = 1'b1;
      wdata = p_q[LinkW-1:0];
    end else if (ctrl_i.tail && have_prev_q && !self_link_q) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      link_mem[waddr] <= wdata;
    end
    rd_q <= link_mem[head_q[IdxW-1:0]];
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    p_d         = p_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    self_link_d = self_link_q;
    out_addr_d  = '0;
    out_sts_d   = STS_OK;

    if (ctrl_i.init_start) begin
      head_d      = NULL_LINK;
      have_prev_d = 1'b0;
      self_link_d = 1'b0;
      p_d         = PW'(first_free_q);
    end
    if (ctrl_i.set_range2) begin
      p_d = PW'(kern_end_q);
    end
    if (ctrl_i.walk_step) begin
      if (!have_prev_q) begin
        head_d = p_q[LinkW-1:0];
      end
      self_link_d = have_prev_q && (PW'(prev_q) == p_q);
      prev_d      = p_q[IdxW-1:0];
      have_prev_d = 1'b1;
      p_d         = p_q + PW'(1);
    end
    if (ctrl_i.free_commit) begin
      if (addr_ok) begin
        head_d = LinkW'(page_idx);
        if (count_q != '0) begin
          count_d = count_q - COUNT_W'(1);
        end
      end else begin
        out_sts_d = STS_BAD_ADDR;
      end
    end
    if (ctrl_i.alloc_commit) begin
      if (head_null) begin
        out_sts_d = STS_EMPTY;
      end else begin
        head_d     = rd_null ? NULL_LINK : rd_q;
        out_addr_d = 32'(head_q[IdxW-1:0]) << PB_LOG;
        if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
        end
      end
    end

    m_valid_d = load_out ? 1'b1 : (m_ready_i ? 1'b0 : m_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= TOTAL_PAGES_RST;
      first_free_q <= FIRST_FREE_RST;
      res_start_q  <= RESERVED_START_RST;
      kern_end_q   <= KERNEL_END_RST;
      min_addr_q   <= MIN_ADDR_RST;
      head_q       <= NULL_LINK;
      count_q      <= '0;
      have_prev_q  <= 1'b0;
      self_link_q  <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TOTAL_PAGES:    total_q      <= cfg_data_i[12:0];
          CFG_FIRST_FREE:     first_free_q <= cfg_data_i[11:0];
          CFG_RESERVED_START: res_start_q  <= cfg_data_i[12:0];
          CFG_KERNEL_END:     kern_end_q   <= cfg_data_i[12:0];
          CFG_MIN_ADDR:       min_addr_q   <= cfg_data_i;
          default:            min_addr_q   <= min_addr_q;
        endcase
      end
      head_q      <= head_d;
      count_q     <= count_d;
      have_prev_q <= have_prev_d;
      self_link_q <= self_link_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    prev_q <= prev_d;
    if (load_out) begin
      out_addr_q <= out_addr_d;
      out_sts_q  <= out_sts_d;
      out_cnt_q  <= count_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = {1'b0, out_cnt_q, out_sts_q, out_addr_q};

endmodule

### rtl/physical_page_free_list_allocator.sv
// physical page allocator keeping free pages as a linked list in a next-page
// table with a head register. commands: init chains the low range, from the
// first free page up to the reserved start page, then [kernel_end_page,
// total_pages), each in ascending order,
// allocate pops the head page and returns its byte address (status empty when
// the list is empty), free pushes a page-aligned address at or above
// min_valid_address back on the head (bad addresses are ignored and flagged),
// query returns the allocated count. every command gives one result word.
// free and query finish from the idle state, allocate passes through a second
// state because the head link comes out of the registered table read port,
// init walks both ranges page by page. the next word is taken once the block
// is idle and the result register is empty or being drained. configuration
// writes are always ready and must only happen while the block is idle. the
// table has no reset; init or frees must write a link before it is followed.
module physical_page_free_list_allocator #(
  parameter int unsigned PAGE_COUNT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input word: command [1:0], address [33:2], zero pad [39:34]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ppfl_pkg::IN_W-1:0]      s_axis_tdata,
  // result word: page_address [31:0], status [33:32], allocated_count [46:34],
  // zero pad [47]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ppfl_pkg::OUT_W-1:0]     m_axis_tdata,
  // register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ppfl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppfl_pkg::CFG_W-1:0]     cfg_data_i
);
  import ppfl_pkg::*;

  ctrl_t ctrl;
  sts_t  sts;
  cmd_e  command;

  // command sits in the low bits, address right above it
  assign command     = cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign cfg_ready_o = 1'b1;

  ppfl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .command_i (command),
    .sts_i     (sts),
    .ctrl_o    (ctrl)
  );

  ppfl_dp #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .sts_o       (sts),
    .address_i   (s_axis_tdata[CMD_W +: ADDR_W]),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata)
  );

endmodule

### dv/tb_physical_page_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_physical_page_free_list_allocator;
  import ppfl_pkg::*;

  localparam int unsigned PAGE_COUNT  = 4096;
  localparam logic [12:0] NULL_PAGE   = 13'(PAGE_COUNT);
  localparam int          CYCLE_LIMIT = 3000000;

  // input word: command, address, zero pad (lowest bits first)
  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] address;
    cmd_e        command;
  } request_word_t;

  // result word: page_address, status, allocated_count, zero pad
  typedef struct packed {
    logic        pad;
    logic [12:0] allocated_count;
    status_e     status;
    logic [31:0] page_address;
  } result_word_t;

  // mirror of the free list plus the queue of result words still owed
  class page_list_scoreboard;
    logic [12:0]  next_page [PAGE_COUNT];
    logic [12:0]  head_page;
    logic [12:0]  in_use;
    logic [12:0]  total_pages;
    logic [11:0]  first_free;
    logic [12:0]  reserved_start;
    logic [12:0]  kernel_end;
    logic [31:0]  min_address;
    result_word_t pending [$];
    int           taken_pages [$];
    int           cmd_seen [4];
    int           rejected, empties, checked, errors, peak;

    function new();
      foreach (next_page[i]) next_page[i] = '0;
      head_page      = NULL_PAGE;
      in_use         = '0;
      total_pages    = TOTAL_PAGES_RST;
      first_free     = FIRST_FREE_RST;
      reserved_start = RESERVED_START_RST;
      kernel_end     = KERNEL_END_RST;
      min_address    = MIN_ADDR_RST;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      rejected = 0;
      empties  = 0;
      checked  = 0;
      errors   = 0;
      peak     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_TOTAL_PAGES:    total_pages    = value[12:0];
        CFG_FIRST_FREE:     first_free     = value[11:0];
        CFG_RESERVED_START: reserved_start = value[12:0];
        CFG_KERNEL_END:     kernel_end     = value[12:0];
        CFG_MIN_ADDR:       min_address    = value;
        default: ;
      endcase
    endfunction

    function void note_command(cmd_e cmd, logic [31:0] addr);
      result_word_t r;
      int           seg, lo, hi, p, page;
      logic [12:0]  prev, nxt;
      r = '0;
      r.status = STS_OK;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_INIT: begin
          // chain the low range, then the range above the kernel
          head_page = NULL_PAGE;
          prev = NULL_PAGE;
          for (seg = 0; seg < 2; seg++) begin
            lo = (seg == 0) ? int'(first_free) : int'(kernel_end);
            hi = (seg == 0) ? int'(reserved_start) : int'(total_pages);
            if (hi > PAGE_COUNT) hi = PAGE_COUNT;
            for (p = lo; p < hi; p++) begin
              next_page[p] = NULL_PAGE;
              if (prev < PAGE_COUNT) next_page[prev] = 13'(p);
              else head_page = 13'(p);
              prev = 13'(p);
            end
          end
        end
        CMD_ALLOC: begin
          if (head_page >= PAGE_COUNT) begin
            r.status = STS_EMPTY;
            empties++;
          end else begin
            r.page_address = 32'(int'(head_page) * PAGE_BYTES);
            if (taken_pages.size() < 512) taken_pages.push_back(int'(head_page));
            nxt = next_page[head_page];
            head_page = (nxt >= PAGE_COUNT) ? NULL_PAGE : nxt;
            if (in_use != COUNT_MAX) in_use++;
          end
        end
        CMD_FREE: begin
          page = int'(addr / PAGE_BYTES);
          if ((addr % PAGE_BYTES) != 0 || addr < min_address || page >= PAGE_COUNT) begin
            r.status = STS_BAD_ADDR;
            rejected++;
          end else begin
            next_page[page] = head_page;
            head_page = 13'(page);
            if (in_use != 0) in_use--;
          end
        end
        default: ;
      endcase
      if (int'(in_use) > peak) peak = int'(in_use);
      r.allocated_count = in_use;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      result_word_t got, want;
      got = data;
      checked++;
      if (pending.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.page_address !== want.page_address) begin
        $error("page_address mismatch: expected %h, actual %h",
               want.page_address, got.page_address);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.allocated_count !== want.allocated_count) begin
        $error("allocated_count mismatch: expected %0d, actual %0d",
               want.allocated_count, got.allocated_count);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  page_list_scoreboard sb;
  bit                  steady;
  int                  hold_left;
  int                  cycle_count;
  int                  layouts;

  physical_page_free_list_allocator #(
    .PAGE_COUNT(PAGE_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random backpressure, none in steady phases
  initial begin
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      @(negedge clk_i);
      if (steady) begin
        hold_left = 0;
        m_axis_tready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        hold_left = idle_cycles();
        m_axis_tready <= (hold_left == 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  task automatic send_word(cmd_e cmd, logic [31:0] addr);
    int            gap;
    request_word_t w;
    gap = steady ? 0 : idle_cycles();
    w.pad     = '0;
    w.address = addr;
    w.command = cmd;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, addr);
  endtask

  // stop sending and wait for every owed result word
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_layout(int total, int first, int reserved, int kernel,
                                logic [31:0] min_addr);
    wait_idle();
    write_reg(CFG_TOTAL_PAGES, 32'(total));
    write_reg(CFG_FIRST_FREE, 32'(first));
    write_reg(CFG_RESERVED_START, 32'(reserved));
    write_reg(CFG_KERNEL_END, 32'(kernel));
    write_reg(CFG_MIN_ADDR, min_addr);
    layouts++;
  endtask

  // addresses the free command must turn away (or a wild one)
  function automatic logic [31:0] bad_address();
    logic [31:0] a;
    case ($urandom_range(0, 3))
      0: a = $urandom();
      1: a = 32'($urandom_range(PAGE_COUNT, 32'hFFFFF) * PAGE_BYTES);
      2: a = 32'($urandom_range(0, PAGE_COUNT - 1) * PAGE_BYTES) |
             (32'd1 << $urandom_range(0, 11));
      default: a = (sb.min_address != 0) ?
                   ($urandom_range(0, sb.min_address - 1) & ~32'hFFF) : 32'hFFFF_FFFF;
    endcase
    return a;
  endfunction

  // init, then a mix of allocate and free with some noise and queries
  task automatic run_traffic(int items, int alloc_pct);
    int          pick, page, idx;
    logic [31:0] addr;
    cmd_e        cmd;
    send_word(CMD_INIT, $urandom());
    repeat (items) begin
      pick = $urandom_range(0, 99);
      addr = $urandom();
      if (pick < 3) begin
        cmd = CMD_INIT;
      end else if (pick < 3 + alloc_pct) begin
        cmd = CMD_ALLOC;
      end else if (pick < 90) begin
        cmd = CMD_FREE;
        if (sb.taken_pages.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx  = $urandom_range(0, sb.taken_pages.size() - 1);
          page = sb.taken_pages[idx];
          sb.taken_pages.delete(idx);
        end else begin
          page = $urandom_range(0, PAGE_COUNT - 1);
        end
        addr = 32'(page * PAGE_BYTES);
      end else if (pick < 95) begin
        cmd  = CMD_FREE;
        addr = bad_address();
      end else begin
        cmd = CMD_QUERY;
      end
      send_word(cmd, addr);
    end
  endtask

  initial begin
    int          ph, base, total, first, reserved, kernel;
    logic [31:0] min_addr;
    sb            = new();
    steady        = 1'b0;
    layouts       = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_TOTAL_PAGES;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the reset layout
    send_word(CMD_ALLOC, 32'h0);           // empty list
    send_word(CMD_FREE, 32'h0000_3000);    // count stays at zero
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_QUERY, 32'hFFFF_FFFF);
    send_word(CMD_FREE, 32'h0000_0001);    // misaligned
    send_word(CMD_FREE, 32'h0100_0000);    // first page past the table
    send_word(CMD_FREE, 32'hFFFF_F000);
    send_word(CMD_FREE, 32'hFFFF_FFFF);
    send_word(CMD_INIT, 32'h0);
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_FREE, 32'h0000_0000);    // lowest page
    send_word(CMD_FREE, 32'h00FF_F000);    // highest page
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_QUERY, 32'h0);
    send_word(CMD_INIT, 32'h5555_5555);    // count kept across init
    send_word(CMD_QUERY, 32'hAAAA_AAAA);

    // directed layouts: full table, minimal, clipped overlap, empty,
    // self loop, second range below its start
    program_layout(4096, 0, 4096, 4096, 32'h0);
    run_traffic(80, 45);
    program_layout(1, 4095, 0, 0, 32'hFFFF_FFFF);
    run_traffic(80, 40);
    program_layout(4096, 4090, 4096, 4000, 32'h0010_0000);
    steady = 1'b1;
    run_traffic(80, 50);
    steady = 1'b0;
    program_layout(4096, 50, 50, 4096, 32'h0);
    run_traffic(80, 35);
    program_layout(6, 2, 6, 5, 32'h0000_5000);
    run_traffic(80, 50);
    program_layout(10, 0, 3, 20, 32'h0000_1000);
    run_traffic(80, 40);

    // random layouts, mostly narrow windows so init stays short
    for (ph = 0; ph < 12; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        total    = $urandom_range(1, 4096);
        first    = $urandom_range(0, 4095);
        reserved = $urandom_range(0, 4096);
        kernel   = $urandom_range(0, 4096);
      end else begin
        base     = $urandom_range(0, 4000);
        first    = base + $urandom_range(0, 8);
        reserved = first + $urandom_range(0, 40);
        kernel   = base + $urandom_range(0, 60);
        total    = kernel + $urandom_range(0, 40);
        if (reserved > 4096) reserved = 4096;
        if (kernel > 4096) kernel = 4096;
        if (total > 4096) total = 4096;
        if (total < 1) total = 1;
      end
      case ($urandom_range(0, 2))
        0: min_addr = 32'h0;
        1: min_addr = $urandom_range(0, (first + 30) * PAGE_BYTES);
        default: min_addr = $urandom();
      endcase
      program_layout(total, first, reserved, kernel, min_addr);
      steady = (ph % 3 == 2);
      run_traffic(100, $urandom_range(30, 55));
    end

    // self loop keeps handing out the same page while the count climbs
    steady = 1'b1;
    program_layout(6, 2, 6, 5, 32'h0);
    send_word(CMD_INIT, 32'h0);
    repeat (60) send_word(CMD_ALLOC, 32'h0);
    send_word(CMD_QUERY, 32'h0);
    send_word(CMD_FREE, 32'h0000_5000);
    send_word(CMD_FREE, 32'h0000_2001);
    send_word(CMD_ALLOC, 32'h0);
    steady = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d result words never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("run: %0d init, %0d allocate (%0d on empty list), %0d free (%0d rejected), %0d query",
             sb.cmd_seen[CMD_INIT], sb.cmd_seen[CMD_ALLOC], sb.empties,
             sb.cmd_seen[CMD_FREE], sb.rejected, sb.cmd_seen[CMD_QUERY]);
    $display("run: %0d layouts programmed, %0d result words checked, peak count %0d",
             layouts, sb.checked, sb.peak);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
